[hdl/tabulated_spectrum_sampler_defines.svh]
// Assertion macros shared by the sampler RTL.
// Included by files that check their own logic; depends on nothing else.
`ifndef TABULATED_SPECTRUM_SAMPLER_DEFINES_SVH
`define TABULATED_SPECTRUM_SAMPLER_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define TSS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/tss_pkg.sv]
// Constants, tables and types for the tabulated spectrum sampler.
// Tables and tail constants are built at elaboration; no dependencies.
package tss_pkg;

   localparam int DRAW_W    = 24;
   localparam int ENERGY_W  = 37;
   localparam int FLUX_W    = 24;
   localparam int ROM_E_W   = 27;
   localparam int ROM_SIZE  = 50;
   localparam int ROM_IDX_W = 6;
   localparam int EXP_STEPS = 24;
   localparam int LOG_W     = 29;

   localparam logic [ENERGY_W-1:0] EMAX = {ENERGY_W{1'b1}};
   localparam logic [23:0] TAIL_EXP_Q24 = 24'd10234102;
   localparam logic [24:0] U_FLOOR      = 25'd17;

   typedef logic [FLUX_W-1:0]  flux_tab_type   [ROM_SIZE];
   typedef logic [ROM_E_W-1:0] energy_tab_type [ROM_SIZE];
   typedef logic [31:0]        exp_tab_type    [EXP_STEPS];

   // decimal flux in units of 1e-4 to Q8.16, rounded
   function automatic logic [FLUX_W-1:0] fq(input longint unsigned v);
      return FLUX_W'((v * 65536 + 5000) / 10000);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // log2 with 24 fraction bits by repeated squaring
   function automatic logic [LOG_W-1:0] log2_q24(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] m;
      logic [23:0] frac;
      int          p;
      int          k;
      x    = (x_in == 0) ? 64'd1 : x_in;
      p    = 0;
      frac = '0;
      for (k = 0; k < 63; k++)
         if ((x >> (k + 1)) != 0) p = k + 1;
      m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
      for (k = 0; k < 24; k++) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac[23-k] = 1'b1;
         end
      end
      return {5'(p), frac};
   endfunction

   // 2^(2^-k) in Q2.30 for k = 1..24
   function automatic exp_tab_type exp_consts();
      exp_tab_type t;
      logic [63:0] c;
      int          k;
      c = isqrt64(64'd2 << 60);
      for (k = 0; k < EXP_STEPS; k++) begin
         t[k] = c[31:0];
         c    = isqrt64(c << 30);
      end
      return t;
   endfunction

   localparam flux_tab_type FLUX_ROM = '{
      fq(78953),   fq(87333),   fq(96432),   fq(106310),  fq(117040),
      fq(128690),  fq(141330),  fq(155050),  fq(169930),  fq(186090),
      fq(203610),  fq(222620),  fq(243230),  fq(265570),  fq(289800),
      fq(316040),  fq(344470),  fq(375260),  fq(408580),  fq(444650),
      fq(483650),  fq(525830),  fq(571400),  fq(620620),  fq(673750),
      fq(731070),  fq(792860),  fq(857630),  fq(922470),  fq(983830),
      fq(1039000), fq(1086300), fq(1125700), fq(1159900), fq(1190600),
      fq(1218300), fq(1243500), fq(1266600), fq(1287800), fq(1307300),
      fq(1324700), fq(1339400), fq(1350700), fq(1358500), fq(1363500),
      fq(1366800), fq(1369100), fq(1370400), fq(1371000), fq(1371200)
   };

   localparam energy_tab_type ENERGY_ROM = '{
      27'd87096000, 27'd81283000, 27'd75857000, 27'd70794000, 27'd66069000,
      27'd61659000, 27'd57544000, 27'd53703000, 27'd50118000, 27'd46773000,
      27'd43651000, 27'd40738000, 27'd38019000, 27'd35481000, 27'd33113000,
      27'd30903000, 27'd28840000, 27'd26915000, 27'd25119000, 27'd23442000,
      27'd21878000, 27'd20417000, 27'd19055000, 27'd17783000, 27'd16596000,
      27'd15488000, 27'd14454000, 27'd13490000, 27'd12589000, 27'd11749000,
      27'd10965000, 27'd10233000, 27'd9549900,  27'd8912500,  27'd8317600,
      27'd7762400,  27'd7244300,  27'd6760800,  27'd6309600,  27'd5888400,
      27'd5495400,  27'd5128600,  27'd4786300,  27'd4466800,  27'd4168700,
      27'd3890400,  27'd3630800,  27'd3388400,  27'd3162300,  27'd2951200
   };

   localparam exp_tab_type       EXP_CONST = exp_consts();
   localparam logic [LOG_W-1:0]  LOG2_F0   = log2_q24(64'(FLUX_ROM[0]));

endpackage

[hdl/tss_if.sv]
// Valid/ready channels for sampler requests and results.
// Depends on tss_pkg for payload widths.
interface tss_req_if import tss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DRAW_W-1:0] uniform_draw;

   modport source (output valid, output uniform_draw, input ready);
   modport sink   (input valid, input uniform_draw, output ready);
endinterface

interface tss_rsp_if import tss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ENERGY_W-1:0] energy_kev;
   logic                in_tail;

   modport source (output valid, output energy_kev, output in_tail, input ready);
   modport sink   (input valid, input energy_kev, input in_tail, output ready);
endinterface

[hdl/tabulated_spectrum_sampler.sv]
// Table path: SB search steps (SB = 6 for 50 entries), then linear interpolation with a
// restoring divide; tail path: normalize, 24 log2 squarings, 24 exp2 products,
// all on one 32x32 multiplier.
// One request at a time: req ready only while idle; the result register frees the
// sequencer, which waits only if a previous result is still untaken.
// Reset (synchronous): sequencer idle, result register empty.
`include "tabulated_spectrum_sampler_defines.svh"

module tabulated_spectrum_sampler import tss_pkg::*; #(
   parameter int TABLE_ENTRIES = 50
) (
   input  logic       clock,
   input  logic       reset,
   tss_req_if.sink    req_chan,
   tss_rsp_if.source  rsp_chan
);

   localparam int NUM   = (TABLE_ENTRIES < 2) ? 2 :
                          ((TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES);
   localparam int SB    = $clog2(NUM);
   localparam int BIT_W = (SB > 1) ? $clog2(SB) : 1;

   localparam logic [FLUX_W-1:0]  FLAST = FLUX_ROM[NUM-1];
   localparam logic [FLUX_W-1:0]  F0    = FLUX_ROM[0];
   localparam logic [ROM_E_W-1:0] E0    = ENERGY_ROM[0];

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_CLASS, ST_SEARCH, ST_PREP, ST_IMUL, ST_DIV, ST_IEND,
      ST_NORM, ST_LOG, ST_EXP, ST_POW, ST_TEND
   } state_type;

   state_type            state_ff, state_in;
   logic [24:0]          u_ff, u_in;
   logic [FLUX_W-1:0]    f_ff, f_in;
   logic [SB-1:0]        cnt_ff, cnt_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [FLUX_W-1:0]    w_ff, w_in;
   logic [FLUX_W-1:0]    t_ff, t_in;
   logic [ROM_E_W-1:0]   el_ff, el_in;
   logic [ROM_E_W-1:0]   diff_ff, diff_in;
   logic [50:0]          rem_ff, rem_in;
   logic [ROM_E_W-1:0]   q_ff, q_in;
   logic [4:0]           k_ff, k_in;
   logic [FLUX_W-1:0]    m_ff, m_in;
   logic [4:0]           p_ff, p_in;
   logic [30:0]          mant_ff, mant_in;
   logic [23:0]          frac_ff, frac_in;
   logic [31:0]          acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0]  energy_ff, energy_in;
   logic                 tail_ff, tail_in;

   logic [31:0]          mul_a, mul_b;
   logic [63:0]          product;
   logic                 out_free;
   logic [24:0]          u_raw;
   logic [FLUX_W-1:0]    f_scaled;
   logic [SB-1:0]        trial, sel;
   logic [ROM_IDX_W-1:0] idx_lo;
   logic [FLUX_W-1:0]    fl, fh, off;
   logic [50:0]          dsub;
   logic [31:0]          sq;
   logic [LOG_W-1:0]     dlog;
   logic [63:0]          rounded, shifted;
   logic [4:0]           sh;

   assign product  = 64'(mul_a) * 64'(mul_b);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.energy_kev = energy_ff;
   assign rsp_chan.in_tail    = tail_ff;

   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      f_in         = f_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      w_in         = w_ff;
      t_in         = t_ff;
      el_in        = el_ff;
      diff_in      = diff_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      p_in         = p_ff;
      mant_in      = mant_ff;
      frac_in      = frac_ff;
      acc_in       = acc_ff;
      energy_in    = energy_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mul_a        = '0;
      mul_b        = '0;

      u_raw    = 25'd1 << DRAW_W;
      u_raw    = u_raw - 25'(req_chan.uniform_draw);
      f_scaled = product[47:24];
      trial    = cnt_ff | (SB'(1) << bit_ff);
      sel      = (cnt_ff == '0) ? '0 : cnt_ff - SB'(1);
      idx_lo   = ROM_IDX_W'(sel);
      fl       = FLUX_ROM[idx_lo];
      fh       = FLUX_ROM[idx_lo + ROM_IDX_W'(1)];
      off      = f_ff - fl;
      dsub     = 51'(w_ff) << k_ff;
      sq       = product[61:30];
      dlog     = LOG2_F0 - {p_ff, frac_ff};
      rounded  = (product + (64'd1 << 29)) >> 30;
      sh       = 5'd30 - p_ff;
      shifted  = product >> sh;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               u_in     = (u_raw < U_FLOOR) ? U_FLOOR : u_raw;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mul_a    = 32'(u_ff);
            mul_b    = 32'(FLAST);
            f_in     = (f_scaled == '0) ? FLUX_W'(1) : f_scaled;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            if (f_ff < F0) begin
               m_in     = f_ff;
               p_in     = 5'd23;
               state_in = ST_NORM;
            end else begin
               cnt_in   = '0;
               bit_in   = BIT_W'(SB - 1);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // bitwise search for the count of entries below f
            if (trial <= SB'(NUM - 1) &&
                FLUX_ROM[ROM_IDX_W'(trial - SB'(1))] < f_ff)
               cnt_in = trial;
            if (bit_ff == '0) state_in = ST_PREP;
            else bit_in = bit_ff - BIT_W'(1);
         end
         ST_PREP: begin
            w_in     = (fh > fl) ? fh - fl : '0;
            t_in     = (off > fh - fl) ? fh - fl : off;
            el_in    = ENERGY_ROM[idx_lo];
            diff_in  = ENERGY_ROM[idx_lo] - ENERGY_ROM[idx_lo + ROM_IDX_W'(1)];
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            mul_a  = 32'(diff_ff);
            mul_b  = 32'(t_ff);
            rem_in = product[50:0];
            q_in   = '0;
            k_in   = 5'(ROM_E_W - 1);
            state_in = (w_ff == '0) ? ST_IEND : ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= dsub) begin
               rem_in = rem_ff - dsub;
               q_in   = {q_ff[ROM_E_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[ROM_E_W-2:0], 1'b0};
            end
            if (k_ff == '0) state_in = ST_IEND;
            else k_in = k_ff - 5'd1;
         end
         ST_IEND: begin
            if (out_free) begin
               energy_in    = ENERGY_W'(el_ff - q_ff);
               tail_in      = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_NORM: begin
            if (m_ff[FLUX_W-1]) begin
               mant_in  = {m_ff, 7'b0};
               frac_in  = '0;
               k_in     = '0;
               state_in = ST_LOG;
            end else begin
               m_in = m_ff << 1;
               p_in = p_ff - 5'd1;
            end
         end
         ST_LOG: begin
            mul_a = {1'b0, mant_ff};
            mul_b = {1'b0, mant_ff};
            if (sq[31]) mant_in = sq[31:1];
            else mant_in = sq[30:0];
            frac_in = {frac_ff[22:0], sq[31]};
            if (k_ff == 5'(EXP_STEPS - 1)) state_in = ST_EXP;
            else k_in = k_ff + 5'd1;
         end
         ST_EXP: begin
            mul_a    = 32'(dlog);
            mul_b    = 32'(TAIL_EXP_Q24);
            p_in     = product[52:48];
            frac_in  = product[47:24];
            acc_in   = 32'd1 << 30;
            k_in     = '0;
            state_in = ST_POW;
         end
         ST_POW: begin
            mul_a = acc_ff;
            mul_b = EXP_CONST[k_ff];
            if (frac_ff[23]) acc_in = rounded[31:0];
            frac_in = frac_ff << 1;
            if (k_ff == 5'(EXP_STEPS - 1)) state_in = ST_TEND;
            else k_in = k_ff + 5'd1;
         end
         ST_TEND: begin
            mul_a = 32'(E0);
            mul_b = acc_ff;
            if (out_free) begin
               if (p_ff >= 5'd12 || shifted[63:ENERGY_W] != '0) energy_in = EMAX;
               else energy_in = shifted[ENERGY_W-1:0];
               tail_in      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      u_ff      <= u_in;
      f_ff      <= f_in;
      cnt_ff    <= cnt_in;
      bit_ff    <= bit_in;
      w_ff      <= w_in;
      t_ff      <= t_in;
      el_ff     <= el_in;
      diff_ff   <= diff_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      k_ff      <= k_in;
      m_ff      <= m_in;
      p_ff      <= p_in;
      mant_ff   <= mant_in;
      frac_ff   <= frac_in;
      acc_ff    <= acc_in;
      energy_ff <= energy_in;
      tail_ff   <= tail_in;
   end

   `TSS_ASSERT_NXT(busy_after_req_a, req_chan.valid && req_chan.ready,
      state_ff != ST_IDLE, "request accepted but sequencer stayed idle")
   `TSS_ASSERT_IMP(search_bound_a, state_ff == ST_SEARCH,
      cnt_ff <= SB'(NUM - 1), "search count past table end")
   `TSS_ASSERT_IMP(div_rem_a, state_ff == ST_DIV,
      rem_ff < (51'(w_ff) << (k_ff + 5'd1)), "divide remainder out of range")
   `TSS_ASSERT_IMP(interp_range_a, rsp_valid_ff && !tail_ff,
      energy_ff <= ENERGY_W'(E0), "table energy above first entry")
   `TSS_ASSERT_IMP(tail_range_a, rsp_valid_ff && tail_ff,
      energy_ff >= ENERGY_W'(E0), "tail energy below first entry")

endmodule
